/* hdl/u8dec_pkg.sv */
// Shared types and constants for the lenient UTF-8 decoder.
`timescale 1ns / 1ps

package u8dec_pkg;

  localparam int unsigned CHAR_W     = 21;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_AW    = $clog2(OBUF_DEPTH);
  localparam int unsigned OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  localparam logic [CHAR_W-1:0] MAX_POINT = 21'h10FFFF;
  localparam logic [CHAR_W-1:0] MIN_SUPP  = 21'h010000;
  localparam logic [CHAR_W-1:0] SURR_HI   = 21'h00D800;
  localparam logic [CHAR_W-1:0] SURR_LO   = 21'h00DC00;

  localparam logic UTF16_MODE_RST = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } dec_res_t;

endpackage

/* hdl/u8dec_dec.sv */
// Decoder stage: sequence state and per-byte result generation.
`timescale 1ns / 1ps

module u8dec_dec
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              utf16_mode_i,
  output dec_res_t          res_o
);

  logic [1:0]        pend_r, pend_nxt;
  logic [CHAR_W-1:0] acc_r, acc_nxt;
  logic [CHAR_W-1:0] cont_acc;
  logic [CHAR_W-1:0] cp;
  logic [CHAR_W-1:0] v;
  logic              emit;

  assign cont_acc = {acc_r[CHAR_W-7:0], byte_i[5:0]};
  assign v        = cp - MIN_SUPP;

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    cp       = '0;
    if (!byte_i[7]) begin
      pend_nxt = 2'd0;
      emit     = 1'b1;
      cp       = {{(CHAR_W-BYTE_W){1'b0}}, byte_i};
    end else if (!byte_i[6]) begin
      if (pend_r != 2'd0) begin
        pend_nxt = pend_r - 2'd1;
        acc_nxt  = cont_acc;
        if (pend_r == 2'd1) begin
          emit = 1'b1;
          cp   = cont_acc;
        end
      end
    end else if (!byte_i[5]) begin
      pend_nxt = 2'd1;
      acc_nxt  = {{(CHAR_W-5){1'b0}}, byte_i[4:0]};
    end else if (!byte_i[4]) begin
      pend_nxt = 2'd2;
      acc_nxt  = {{(CHAR_W-4){1'b0}}, byte_i[3:0]};
    end else if (!byte_i[3]) begin
      pend_nxt = 2'd3;
      acc_nxt  = {{(CHAR_W-3){1'b0}}, byte_i[2:0]};
    end else begin
      pend_nxt = 2'd0;
    end
  end

  always_comb begin
    res_o = '0;
    if (emit && (cp <= MAX_POINT)) begin
      if (utf16_mode_i && (cp >= MIN_SUPP)) begin
        res_o.cnt     = 2'd2;
        res_o.r0.ch   = SURR_HI | {{(CHAR_W-10){1'b0}}, v[19:10]};
        res_o.r0.last = 1'b0;
        res_o.r1.ch   = SURR_LO | {{(CHAR_W-10){1'b0}}, v[9:0]};
        res_o.r1.last = 1'b1;
      end else begin
        res_o.cnt     = 2'd1;
        res_o.r0.ch   = cp;
        res_o.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (fire_i) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    res_o.cnt == 2'd1 |-> res_o.r0.last)
    else $error("single result without last flag");

  a_pair_order : assert property (@(posedge clk) disable iff (!rst_n)
    res_o.cnt == 2'd2 |-> (!res_o.r0.last && res_o.r1.last && res_o.r0.ch[15:10] == 6'h36))
    else $error("surrogate pair malformed");

endmodule

/* hdl/u8dec_obuf.sv */
// Result buffer: takes up to two results per cycle, delivers one.
`timescale 1ns / 1ps

module u8dec_obuf
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dec_res_t          push_i,
  output logic              room_o,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_last_of_item
);

  res_t               mem_r [OBUF_DEPTH];
  logic [OBUF_AW-1:0] wp_r, rp_r;
  logic [OBUF_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;
  logic [OBUF_AW-1:0] wp1;

  assign wp1              = wp_r + OBUF_AW'(1);
  assign out_valid        = (cnt_r != '0);
  assign pop              = out_valid && out_ready;
  assign room_o           = (cnt_r <= OBUF_CW'(OBUF_DEPTH - 2));
  assign out_char_out     = mem_r[rp_r].ch;
  assign out_last_of_item = mem_r[rp_r].last;
  assign cnt_nxt          = cnt_r + OBUF_CW'(push_i.cnt) - OBUF_CW'(pop);

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) begin
      mem_r[wp_r] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_r[wp1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + OBUF_AW'(push_i.cnt);
      rp_r  <= rp_r + OBUF_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push_i.cnt != 2'd0 |-> room_o)
    else $error("push into full result buffer");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OBUF_CW'(OBUF_DEPTH))
    else $error("result count out of range");

  a_cnt_track : assert property (@(posedge clk) disable iff (!rst_n)
    pop && push_i.cnt == 2'd0 |=> cnt_r == $past(cnt_r) - OBUF_CW'(1))
    else $error("result count lost track");

endmodule

/* hdl/lenient_utf8_to_utf32_utf16_decoder_core.sv */
// Top level: lenient UTF-8 decoder to UTF-32 code points or UTF-16 units.
//
// Input channel (in_valid/in_ready/in_byte_in) carries one UTF-8 byte per item.
// Result channel (out_valid/out_ready/out_char_out/out_last_of_item) carries
// 0, 1 or 2 results per byte; out_last_of_item marks the final result of a byte.
// Configuration channel (cfg_valid/cfg_ready/cfg_utf16_mode) writes the mode
// bit; write it only while no byte is in flight. cfg_ready is always high.
// A byte passes the input register, then is decoded into the result buffer,
// from which its results are offered.
// Throughput: one byte per cycle while the buffer has room, set by the
// single-pass decode between the input register and the four-entry result
// buffer. A surrogate pair is two results; a buffer with over two holds off input.
// Reset: clears the pending sequence, empties the buffer and sets UTF-16 mode.
// Receiver stall: results collect in the buffer; once it holds more than two,
// the decoder waits, the input register fills and in_ready drops.
`timescale 1ns / 1ps

module lenient_utf8_to_utf32_utf16_decoder_core
  import u8dec_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_last_of_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_utf16_mode
);

  logic              mode_r;
  logic              inb_vld_r;
  logic [BYTE_W-1:0] inb_byte_r;
  logic              room;
  logic              dec_fire;
  dec_res_t          dec_res;
  dec_res_t          push;

  assign cfg_ready = 1'b1;
  assign dec_fire  = inb_vld_r && room;
  assign in_ready  = !inb_vld_r || dec_fire;

  always_comb begin
    push = dec_res;
    if (!dec_fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= UTF16_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_utf16_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inb_vld_r <= 1'b0;
    end else if (in_ready) begin
      inb_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inb_byte_r <= in_byte_in;
    end
  end

  u8dec_dec u_dec (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire_i       (dec_fire),
    .byte_i       (inb_byte_r),
    .utf16_mode_i (mode_r),
    .res_o        (dec_res)
  );

  u8dec_obuf u_obuf (
    .clk              (clk),
    .rst_n            (rst_n),
    .push_i           (push),
    .room_o           (room),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_out     (out_char_out),
    .out_last_of_item (out_last_of_item)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the lenient UTF-8 decoder core, with a scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import u8dec_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int STALL_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_byte_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char_out;
  logic out_last_of_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_utf16_mode = 1'b0;

  logic [BYTE_W-1:0] utf8_stream[$];
  res_t expected_units[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic send_hold = 1'b0;
  logic stall_req = 1'b0;
  logic recv_stall = 1'b0;
  int err_count = 0;
  int cycle_cnt = 0;

  logic split_mode;
  logic [1:0] cont_left;
  logic [CHAR_W-1:0] point_acc;

  lenient_utf8_to_utf32_utf16_decoder_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte_in(in_byte_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char_out(out_char_out),
    .out_last_of_item(out_last_of_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_utf16_mode(cfg_utf16_mode)
  );

  always #6 clk = ~clk;

  function automatic void emit_point(logic [CHAR_W-1:0] cp);
    logic [CHAR_W-1:0] v;
    res_t r;
    if (cp > MAX_POINT) return;
    if (split_mode && cp >= MIN_SUPP) begin
      v = cp - MIN_SUPP;
      r.ch = SURR_HI + (v >> 10);
      r.last = 1'b0;
      expected_units.push_back(r);
      r.ch = SURR_LO + {11'b0, v[9:0]};
      r.last = 1'b1;
      expected_units.push_back(r);
    end else begin
      r.ch = cp;
      r.last = 1'b1;
      expected_units.push_back(r);
    end
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b);
    if (b < 8'h80) begin
      cont_left = 2'd0;
      emit_point({13'b0, b});
    end else if (b < 8'hC0) begin
      if (cont_left != 2'd0) begin
        cont_left = cont_left - 2'd1;
        point_acc = {point_acc[14:0], b[5:0]};
        if (cont_left == 2'd0) emit_point(point_acc);
      end
    end else if (b < 8'hE0) begin
      cont_left = 2'd1;
      point_acc = {16'b0, b[4:0]};
    end else if (b < 8'hF0) begin
      cont_left = 2'd2;
      point_acc = {17'b0, b[3:0]};
    end else if (b < 8'hF8) begin
      cont_left = 2'd3;
      point_acc = {18'b0, b[2:0]};
    end else begin
      cont_left = 2'd0;
    end
  endfunction

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= 10) $display("tb_top: %s", what);
  endtask

  // driver and prediction of accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      split_mode = UTF16_MODE_RST;
      cont_left = 2'd0;
      point_acc = '0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte_in);
      if (!in_valid || in_ready) begin
        if (utf8_stream.size() != 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_byte_in <= utf8_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // configuration write completes here
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      split_mode = cfg_utf16_mode;
      cfg_valid <= 1'b0;
    end
  end

  // receiver and scoreboard
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        flag_error($sformatf("unexpected item char=%h last=%b", out_char_out, out_last_of_item));
      end else begin
        e = expected_units.pop_front();
        if (out_char_out !== e.ch || out_last_of_item !== e.last)
          flag_error($sformatf("mismatch: expected char=%h last=%b, got char=%h last=%b",
                               e.ch, e.last, out_char_out, out_last_of_item));
      end
    end
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_stall && ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off
  initial begin
    wait (stall_req);
    @(posedge clk);
    recv_stall <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    recv_stall <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic void push_lead(int len);
    case (len)
      1: utf8_stream.push_back(8'($urandom_range(127)));
      2: utf8_stream.push_back(8'hC0 | 8'($urandom_range(31)));
      3: utf8_stream.push_back(8'hE0 | 8'($urandom_range(15)));
      default: utf8_stream.push_back(8'hF0 | 8'($urandom_range(7)));
    endcase
  endfunction

  function automatic void add_random(int n);
    int start;
    int len;
    int r;
    start = utf8_stream.size();
    while (utf8_stream.size() - start < n) begin
      r = $urandom_range(99);
      len = $urandom_range(1, 4);
      if (r < 75) begin
        push_lead(len);
        repeat (len - 1) utf8_stream.push_back(rand_cont());
      end else if (r < 90) begin
        utf8_stream.push_back(8'($urandom_range(255)));
      end else begin
        if (len == 1) len = 4;
        push_lead(len);
        repeat ($urandom_range(len - 2)) utf8_stream.push_back(rand_cont());
      end
    end
  endfunction

  function automatic void add_directed();
    logic [BYTE_W-1:0] seq[] = '{
      8'h00, 8'h7F,
      8'hE2, 8'h82, 8'hAC,
      8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hF4, 8'h8F, 8'hBF, 8'hBF,
      8'hF4, 8'h90, 8'h80, 8'h80,
      8'h80,
      8'hE2, 8'h41,
      8'hE2, 8'hC3, 8'hA9,
      8'hF0, 8'hFF
    };
    foreach (seq[i]) utf8_stream.push_back(seq[i]);
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (utf8_stream.size() != 0 || in_valid || expected_units.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_utf16_mode <= m;
    do @(negedge clk); while (cfg_valid);
  endtask

  task automatic set_idle(input int s, input int r);
    @(posedge clk);
    send_idle_pct <= s;
    recv_idle_pct <= r;
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 73;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_directed();
    add_random(250);
    wait_drained();

    write_mode(1'b0);
    add_random(300);
    wait_drained();

    write_mode(1'b1);
    set_idle(73, 29);
    @(negedge clk);
    add_random(300);
    // pause the sender until all results are back
    do @(negedge clk); while (utf8_stream.size() > 150);
    @(posedge clk);
    send_hold <= 1'b1;
    do @(negedge clk); while (in_valid || expected_units.size() != 0);
    repeat (8) @(negedge clk);
    @(posedge clk);
    send_hold <= 1'b0;
    wait_drained();

    write_mode(1'b0);
    set_idle(0, 0);
    @(negedge clk);
    add_random(150);
    wait_drained();

    write_mode(1'b1);
    @(negedge clk);
    add_random(200);
    @(posedge clk);
    stall_req <= 1'b1;
    wait_drained();

    repeat (20) @(negedge clk);
    if (err_count == 0 && expected_units.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
